FILE: sv/binary_image_thinning_defines.svh
// Assertion macros for the binary image thinning block
`ifndef BINARY_IMAGE_THINNING_DEFINES_SVH
`define BINARY_IMAGE_THINNING_DEFINES_SVH
`ifndef SYNTH
`define BIMTHIN_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define BIMTHIN_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define BIMTHIN_ASSERT_IMP(label, clk, rst_n, a, c)
`define BIMTHIN_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: sv/bimthin_pkg.sv
// Constants, codes and the pixel deletion rule of the thinning block
package bimthin_pkg;
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int DIM_W      = 9;
	localparam int PIX_W      = 8;
	localparam int PASS_W     = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [PIX_W-1:0]  FG_VALUE = 8'd255;
	localparam logic [3:0]        MIN_NB   = 4'd2;
	localparam logic [3:0]        MAX_NB   = 4'd6;
	localparam logic [DIM_W-1:0]  DIM_MIN  = 9'd3;
	localparam logic [DIM_W-1:0]  DIM_MAXW = 9'(MAX_WIDTH);
	localparam logic [DIM_W-1:0]  DIM_MAXH = 9'(MAX_HEIGHT);

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_RUN   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

	// ring order: N NE E SE S SW W NW
	function automatic logic thin_del(input logic [7:0] p, input logic second);
		logic [3:0] cnt;
		logic [3:0] trans;
		logic       prod;
		cnt   = '0;
		trans = '0;
		for (int k = 0; k < 8; k++) begin
			cnt = cnt + {3'd0, p[k]};
			if (!p[k] && p[(k + 1) % 8])
				trans = trans + 4'd1;
		end
		if (!second)
			prod = (p[0] & p[2] & p[4]) | (p[2] & p[4] & p[6]);
		else
			prod = (p[0] & p[2] & p[6]) | (p[0] & p[4] & p[6]);
		return (cnt >= MIN_NB) && (cnt <= MAX_NB) && (trans == 4'd1) && !prod;
	endfunction
endpackage

FILE: sv/bimthin_in_if.sv
// Command channel: operation, address and pixel
interface bimthin_in_if;
	import bimthin_pkg::*;
	logic             valid;
	logic             ready;
	logic [1:0]       operation;
	logic [ROW_W-1:0] row;
	logic [COL_W-1:0] col;
	logic [PIX_W-1:0] pixel_value;
	modport source (output valid, operation, row, col, pixel_value, input ready);
	modport sink (input valid, operation, row, col, pixel_value, output ready);
endinterface

FILE: sv/bimthin_out_if.sv
// Result channel: pixel read back, sub-pass count, status
interface bimthin_out_if;
	import bimthin_pkg::*;
	logic              valid;
	logic              ready;
	logic [PIX_W-1:0]  read_pixel;
	logic [PASS_W-1:0] pass_count;
	logic              status;
	modport source (output valid, read_pixel, pass_count, status, input ready);
	modport sink (input valid, read_pixel, pass_count, status, output ready);
endinterface

FILE: sv/bimthin_ram.sv
// Generic simple dual-port RAM, one write and one registered read port
module bimthin_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

FILE: sv/binary_image_thinning.sv
// Binary image thinning top level: row-wide frame store and sub-pass sweep
//
//  channel  dir  payload
//  req      in   operation, row, col, pixel_value
//  rsp      out  read_pixel, pass_count, status
//  cfg      in   cfg_we, cfg_index, cfg_wdata (write only)
//
// Frame RAM holds one image row per word. A write reads the row, then writes it back updated;
// a read fetches the row and picks the pixel; out-of-range and unused commands answer without a RAM access.
// A run sweeps all rows once per sub-pass (one row read per cycle, 3-row window),
// repeated until a sub-pass deletes nothing.
// Reset is asynchronous; the frame RAM is not cleared. req stalls while a command works
// or the result register is still held by rsp.
module binary_image_thinning (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [bimthin_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bimthin_pkg::DIM_W-1:0]         cfg_wdata,
	bimthin_in_if.sink                            req,
	bimthin_out_if.source                         rsp
);
	import bimthin_pkg::*;
	`include "binary_image_thinning_defines.svh"

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ACC  = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;

	logic [1:0]           state_q;
	logic [DIM_W-1:0]     width_q, height_q, cfg_clamped, maxd;
	logic [1:0]           op_q;
	logic [ROW_W-1:0]     row_q;
	logic [COL_W-1:0]     col_q;
	logic                 fg_q;
	logic [DIM_W-1:0]     rd_row_q;
	logic                 rv_s1;
	logic [ROW_W-1:0]     ridx_s1;
	logic [MAX_WIDTH-1:0] top_q, mid_q, bot_q, new_mid, del_row, mod_row;
	logic [ROW_W-1:0]     bidx_q;
	logic                 wv_q, any_q, second_q;
	logic [PASS_W-1:0]    passes_q, passes_inc;
	logic                 out_v_q;
	logic [PIX_W-1:0]     out_pix_q;
	logic                 out_st_q;
	logic                 accept, oob, is_rw, rd_issue, row_wr, pass_end, any_next;
	logic                 out_load;
	logic                 mem_we, mem_re;
	logic [ROW_W-1:0]     mem_waddr, mem_raddr;
	logic [MAX_WIDTH-1:0] mem_wdata, mem_rdata;

	// configuration clamp
	always_comb begin
		maxd = (cfg_index == REG_WIDTH) ? DIM_MAXW : DIM_MAXH;
		if (cfg_wdata < DIM_MIN)
			cfg_clamped = DIM_MIN;
		else if (cfg_wdata > maxd)
			cfg_clamped = maxd;
		else
			cfg_clamped = cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_MAXW;
			height_q <= DIM_MAXH;
		end else if (cfg_we) begin
			if (cfg_index == REG_WIDTH)
				width_q <= cfg_clamped;
			else if (cfg_index == REG_HEIGHT)
				height_q <= cfg_clamped;
		end
	end

	// handshake and command decode
	assign req.ready = (state_q == ST_IDLE) && (!out_v_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign is_rw     = (req.operation == OP_WRITE) || (req.operation == OP_READ);
	assign oob       = ({1'b0, req.row} >= height_q) || ({1'b0, req.col} >= width_q);
	assign rd_issue  = (state_q == ST_RUN) && (rd_row_q < height_q);

	// deletion of the window's middle row, interior columns only
	always_comb begin
		del_row = '0;
		for (int c = 1; c < MAX_WIDTH - 1; c++) begin
			if (mid_q[c] && (DIM_W'(c) + 9'd2 <= width_q))
				del_row[c] = thin_del({top_q[c-1], mid_q[c-1], bot_q[c-1], bot_q[c],
					bot_q[c+1], mid_q[c+1], top_q[c+1], top_q[c]}, second_q);
		end
		new_mid = mid_q & ~del_row;
	end

	assign row_wr     = wv_q && (bidx_q >= ROW_W'(2));
	assign pass_end   = wv_q && ({1'b0, bidx_q} == height_q - 9'd1);
	assign any_next   = any_q || (row_wr && (del_row != '0));
	assign passes_inc = (passes_q == '1) ? passes_q : passes_q + 16'd1;

	// result register loads a new beat this cycle
	assign out_load = (state_q == ST_ACC) || ((state_q == ST_RUN) && pass_end && !any_next) ||
		(accept && (req.operation != OP_RUN) && !(is_rw && !oob));

	// pixel update of a fetched row
	always_comb begin
		mod_row        = mem_rdata;
		mod_row[col_q] = fg_q;
	end

	// frame RAM port selection
	assign mem_re    = (accept && is_rw && !oob) || rd_issue;
	assign mem_raddr = (state_q == ST_RUN) ? rd_row_q[ROW_W-1:0] : req.row;
	assign mem_we    = ((state_q == ST_ACC) && (op_q == OP_WRITE)) || row_wr;
	assign mem_waddr = (state_q == ST_ACC) ? row_q : bidx_q - ROW_W'(1);
	assign mem_wdata = (state_q == ST_ACC) ? mod_row : new_mid;

	bimthin_ram #(.WIDTH(MAX_WIDTH), .DEPTH(MAX_HEIGHT)) u_frame (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// row window for the sweep
	always_ff @(posedge clk) begin
		ridx_s1 <= rd_row_q[ROW_W-1:0];
		if (rv_s1) begin
			top_q  <= mid_q;
			mid_q  <= bot_q;
			bot_q  <= mem_rdata;
			bidx_q <= ridx_s1;
		end
		if (accept) begin
			op_q  <= req.operation;
			row_q <= req.row;
			col_q <= req.col;
			fg_q  <= (req.pixel_value == FG_VALUE);
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_row_q  <= '0;
			rv_s1     <= 1'b0;
			wv_q      <= 1'b0;
			any_q     <= 1'b0;
			second_q  <= 1'b0;
			passes_q  <= '0;
			out_v_q   <= 1'b0;
			out_pix_q <= '0;
			out_st_q  <= 1'b0;
		end else begin
			rv_s1 <= rd_issue;
			wv_q  <= rv_s1;
			if (rsp.ready && !out_load)
				out_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.operation == OP_RUN) begin
							state_q  <= ST_RUN;
							passes_q <= 16'd1;
							rd_row_q <= '0;
							any_q    <= 1'b0;
							second_q <= 1'b0;
						end else if (is_rw && !oob) begin
							state_q <= ST_ACC;
						end else begin
							out_v_q   <= 1'b1;
							out_pix_q <= '0;
							out_st_q  <= is_rw;
						end
					end
				end
				ST_ACC: begin
					state_q   <= ST_IDLE;
					out_v_q   <= 1'b1;
					out_st_q  <= 1'b0;
					out_pix_q <= (op_q == OP_READ && mem_rdata[col_q]) ? FG_VALUE : '0;
				end
				ST_RUN: begin
					if (rd_issue)
						rd_row_q <= rd_row_q + 9'd1;
					if (row_wr && !pass_end)
						any_q <= any_next;
					if (pass_end) begin
						if (!any_next) begin
							state_q   <= ST_IDLE;
							out_v_q   <= 1'b1;
							out_pix_q <= '0;
							out_st_q  <= 1'b0;
						end else begin
							passes_q <= passes_inc;
							second_q <= !second_q;
							rd_row_q <= '0;
							any_q    <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.read_pixel = out_pix_q;
	assign rsp.pass_count = passes_q;
	assign rsp.status     = out_st_q;

	// checks
	`BIMTHIN_ASSERT_IMP(a_no_idle_write, clk, arst_n, mem_we, state_q != ST_IDLE)
	`BIMTHIN_ASSERT_NXT(a_accept_busy, clk, arst_n, accept, state_q != ST_IDLE || out_v_q)
	`BIMTHIN_ASSERT_IMP(a_run_stalls, clk, arst_n, state_q == ST_RUN, !req.ready && !mem_we || row_wr)
endmodule

FILE: bench/tb_binary_image_thinning.sv
// Testbench for binary_image_thinning: directed table, then random phases against a predictor
module tb_binary_image_thinning;
	timeunit 1ns;
	timeprecision 1ps;
	import bimthin_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [PIX_W-1:0]  pix;
		logic [PASS_W-1:0] passes;
		logic              st;
	} thin_rsp_t;

	typedef struct {
		logic [1:0] op;
		logic [7:0] r;
		logic [7:0] c;
		logic [7:0] v;
		bit         known;
		thin_rsp_t  res;
	} cmd_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0] cfg_wdata = '0;

	bimthin_in_if req ();
	bimthin_out_if rsp ();

	binary_image_thinning dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .req(req.sink), .rsp(rsp.source)
	);

	always #5 clk = ~clk;

	// predictor state
	bit frame_img [0:MAX_WIDTH*MAX_HEIGHT-1];
	bit del_mark [0:MAX_WIDTH*MAX_HEIGHT-1];
	int img_w = MAX_WIDTH;
	int img_h = MAX_HEIGHT;
	int sub_passes = 0;

	thin_rsp_t expected_q [$];
	int errors = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	int stall_cycles = 0;

	// shapes for blob images
	int rect_r0 [4], rect_c0 [4], rect_r1 [4], rect_c1 [4];

	task automatic report(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
		errors++;
	endtask

	function automatic bit thin_sweep(input bit second);
		bit any;
		int base;
		bit [7:0] p;
		int cnt, trans;
		bit prod;
		any = 1'b0;
		for (int r = 1; r + 1 < img_h; r++)
			for (int c = 1; c + 1 < img_w; c++) begin
				base = r * MAX_WIDTH + c;
				if (frame_img[base]) begin
					p[0] = frame_img[base - MAX_WIDTH];
					p[1] = frame_img[base - MAX_WIDTH + 1];
					p[2] = frame_img[base + 1];
					p[3] = frame_img[base + MAX_WIDTH + 1];
					p[4] = frame_img[base + MAX_WIDTH];
					p[5] = frame_img[base + MAX_WIDTH - 1];
					p[6] = frame_img[base - 1];
					p[7] = frame_img[base - MAX_WIDTH - 1];
					cnt = 0;
					trans = 0;
					for (int k = 0; k < 8; k++) begin
						cnt += p[k];
						if (!p[k] && p[(k + 1) % 8]) trans++;
					end
					prod = second ? ((p[0] & p[2] & p[6]) | (p[0] & p[4] & p[6]))
					              : ((p[0] & p[2] & p[4]) | (p[2] & p[4] & p[6]));
					if (cnt >= 2 && cnt <= 6 && trans == 1 && !prod) begin
						del_mark[base] = 1'b1;
						any = 1'b1;
					end
				end
			end
		if (any)
			for (int k = 0; k < MAX_WIDTH*MAX_HEIGHT; k++)
				if (del_mark[k]) begin
					frame_img[k] = 1'b0;
					del_mark[k] = 1'b0;
				end
		return any;
	endfunction

	function automatic void bump_passes();
		if (sub_passes < 65535) sub_passes++;
	endfunction

	function automatic thin_rsp_t thin_predict(input logic [1:0] op, input logic [7:0] r,
			input logic [7:0] c, input logic [7:0] v);
		thin_rsp_t res;
		res = '0;
		if (op == OP_WRITE || op == OP_READ) begin
			if (r >= img_h || c >= img_w)
				res.st = 1'b1;
			else if (op == OP_WRITE)
				frame_img[r * MAX_WIDTH + c] = (v == FG_VALUE);
			else
				res.pix = frame_img[r * MAX_WIDTH + c] ? FG_VALUE : 8'd0;
		end else if (op == OP_RUN) begin
			sub_passes = 0;
			forever begin
				bump_passes();
				if (!thin_sweep(1'b0)) break;
				bump_passes();
				if (!thin_sweep(1'b1)) break;
			end
		end
		res.passes = sub_passes[15:0];
		return res;
	endfunction

	// drive one command beat; returns once accepted
	task automatic send_cmd(input logic [1:0] op, input logic [7:0] r, input logic [7:0] c,
			input logic [7:0] v, input bit known = 1'b0, input thin_rsp_t res = '0);
		thin_rsp_t pred;
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			@(negedge clk);
			req.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req.valid <= 1'b1;
		req.operation <= op;
		req.row <= r;
		req.col <= c;
		req.pixel_value <= v;
		do @(posedge clk); while (!req.ready);
		pred = thin_predict(op, r, c, v);
		expected_q.insert(expected_q.size(), known ? res : pred);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req.valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (5) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WIDTH) img_w = (val < 3) ? 3 : (val > MAX_WIDTH ? MAX_WIDTH : val);
		else if (idx == REG_HEIGHT)
			img_h = (val < 3) ? 3 : (val > MAX_HEIGHT ? MAX_HEIGHT : val);
	endtask

	function automatic logic [7:0] pick_pixel(input bit fg);
		return fg ? FG_VALUE : 8'($urandom_range(0, 254));
	endfunction

	// load the whole used area: random speckle or thick rectangles
	task automatic fill_frame(input bit blobs);
		bit fg;
		for (int k = 0; k < 4; k++) begin
			rect_r0[k] = $urandom_range(0, img_h - 1);
			rect_c0[k] = $urandom_range(0, img_w - 1);
			rect_r1[k] = rect_r0[k] + $urandom_range(1, img_h / 2 + 2);
			rect_c1[k] = rect_c0[k] + $urandom_range(1, img_w / 2 + 2);
		end
		for (int r = 0; r < img_h; r++)
			for (int c = 0; c < img_w; c++) begin
				fg = 1'b0;
				if (blobs) begin
					for (int k = 0; k < 4; k++)
						if (r >= rect_r0[k] && r <= rect_r1[k] && c >= rect_c0[k] && c <= rect_c1[k])
							fg = 1'b1;
				end else
					fg = 1'($urandom_range(0, 1));
				send_cmd(OP_WRITE, 8'(r), 8'(c), pick_pixel(fg));
			end
	endtask

	// random mix of commands over a fully loaded frame
	task automatic random_cmds(input int n);
		int sel;
		logic [7:0] r, c;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			if ($urandom_range(0, 9) == 0) begin
				r = 8'($urandom);
				c = 8'($urandom);
			end else begin
				r = 8'($urandom_range(0, img_h - 1));
				c = 8'($urandom_range(0, img_w - 1));
			end
			if (sel < 45) send_cmd(OP_WRITE, r, c, pick_pixel(1'($urandom_range(0, 1))));
			else if (sel < 85) send_cmd(OP_READ, r, c, 8'($urandom));
			else if (sel < 94) send_cmd(OP_RUN, 8'($urandom), 8'($urandom), 8'($urandom));
			else send_cmd(OP_NONE, 8'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	cmd_row_t directed [] = '{
		'{OP_NONE,  8'd0,   8'd0,   8'd0,   1'b1, '{8'd0, 16'd0, 1'b0}},
		'{OP_WRITE, 8'd0,   8'd0,   8'd255, 1'b1, '{8'd0, 16'd0, 1'b0}},
		'{OP_WRITE, 8'd0,   8'd1,   8'd255, 1'b0, '0},
		'{OP_WRITE, 8'd0,   8'd2,   8'd0,   1'b0, '0},
		'{OP_WRITE, 8'd1,   8'd0,   8'd255, 1'b0, '0},
		'{OP_WRITE, 8'd1,   8'd1,   8'd255, 1'b0, '0},
		'{OP_WRITE, 8'd1,   8'd2,   8'd254, 1'b0, '0},
		'{OP_WRITE, 8'd2,   8'd0,   8'd1,   1'b0, '0},
		'{OP_WRITE, 8'd2,   8'd1,   8'd255, 1'b0, '0},
		'{OP_WRITE, 8'd2,   8'd2,   8'd128, 1'b0, '0},
		'{OP_WRITE, 8'd3,   8'd0,   8'd255, 1'b1, '{8'd0, 16'd0, 1'b1}},
		'{OP_WRITE, 8'd0,   8'd255, 8'd255, 1'b1, '{8'd0, 16'd0, 1'b1}},
		'{OP_READ,  8'd255, 8'd255, 8'd0,   1'b1, '{8'd0, 16'd0, 1'b1}},
		'{OP_READ,  8'd2,   8'd3,   8'd0,   1'b1, '{8'd0, 16'd0, 1'b1}},
		'{OP_READ,  8'd0,   8'd0,   8'd0,   1'b1, '{8'd255, 16'd0, 1'b0}},
		'{OP_READ,  8'd0,   8'd2,   8'd0,   1'b1, '{8'd0, 16'd0, 1'b0}},
		'{OP_READ,  8'd1,   8'd1,   8'd0,   1'b0, '0},
		'{OP_RUN,   8'd255, 8'd255, 8'd255, 1'b0, '0},
		'{OP_READ,  8'd1,   8'd1,   8'd0,   1'b0, '0},
		'{OP_NONE,  8'd255, 8'd255, 8'd255, 1'b0, '0},
		'{OP_RUN,   8'd0,   8'd0,   8'd0,   1'b0, '0},
		'{OP_READ,  8'd2,   8'd2,   8'd0,   1'b0, '0}
	};

	// result side: random stall bursts, long hold on request
	initial begin
		int burst;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				rsp.ready <= 1'b0;
				for (int i = 1; i < HOLD_CYCLES; i++) @(negedge clk);
				hold_req = 1'b0;
				rsp.ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 19);
				rsp.ready <= 1'b0;
				repeat (burst - 1) @(negedge clk);
			end else
				rsp.ready <= 1'b1;
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		thin_rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_q.size() == 0) begin
				report("result beat with none expected", 1, 0);
			end else begin
				want = expected_q.pop_front();
				if (rsp.read_pixel !== want.pix) report("read_pixel", rsp.read_pixel, want.pix);
				if (rsp.pass_count !== want.passes) report("pass_count", rsp.pass_count, want.passes);
				if (rsp.status !== want.st) report("status", rsp.status, want.st);
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we)
			stall_cycles <= 0;
		else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		int w, h;
		req.valid = 1'b0;
		req.operation = OP_NONE;
		req.row = '0;
		req.col = '0;
		req.pixel_value = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// smallest frame via clamping; spare indexes must do nothing
		cfg_write(REG_WIDTH, 9'd0);
		cfg_write(REG_HEIGHT, 9'd1);
		cfg_write(REG_SPARE_A, 9'h1FF);
		cfg_write(REG_SPARE_B, 9'h0AA);
		foreach (directed[i])
			send_cmd(directed[i].op, directed[i].r, directed[i].c, directed[i].v,
			         directed[i].known, directed[i].res);
		wait_drained();

		// full-size frame, width clamped down from the top code; only touched pixels read
		cfg_write(REG_WIDTH, 9'h1FF);
		cfg_write(REG_HEIGHT, 9'h100);
		send_cmd(OP_WRITE, 8'd255, 8'd255, 8'd255);
		send_cmd(OP_WRITE, 8'd0, 8'd255, 8'd7);
		send_cmd(OP_WRITE, 8'd255, 8'd0, 8'd255);
		send_cmd(OP_READ, 8'd255, 8'd255, 8'd0);
		send_cmd(OP_READ, 8'd0, 8'd255, 8'd0);
		send_cmd(OP_READ, 8'd255, 8'd0, 8'd0);
		wait_drained();

		// small and skinny frames
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin w = 3; h = 12; end
				1: begin w = 12; h = 3; end
				default: begin w = $urandom_range(3, 9); h = $urandom_range(3, 9); end
			endcase
			cfg_write(REG_WIDTH, 9'(w));
			cfg_write(REG_HEIGHT, 9'(h));
			if (ph == 7) quiet = 1'b1;
			fill_frame(1'(ph % 2));
			send_cmd(OP_RUN, 8'd0, 8'd0, 8'd0);
			if (ph == 3) hold_req = 1'b1;
			random_cmds(10);
			wait_drained();
		end

		repeat (20) @(negedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("Verification passed");
		else begin
			if (expected_q.size() != 0)
				report("results never arrived", expected_q.size(), 0);
			$display("Verification failed");
		end
		$finish;
	end
endmodule
